// ===== src/flfbh_pkg.sv =====
// Package for the four-lane block hash: lane constants, the queue entry type
// and the hash engine state type. No dependencies.
package flfbh_pkg;

  localparam int unsigned NumLanes  = 4;
  localparam int unsigned LaneW     = 32;
  localparam int unsigned BlockW    = NumLanes * LaneW;
  localparam int unsigned CountW    = 5;

  localparam logic [LaneW-1:0] LaneSeed = 32'h811c_9dc5;
  localparam logic [LaneW-1:0] LaneMult = 32'h0100_0193;
  localparam logic [LaneW-1:0] FoldMask = 32'hDFDF_DFDF;

  typedef logic [NumLanes-1:0][LaneW-1:0] lanes_t;

  // One classified block, as handed from the front end to the hash engine.
  typedef struct packed {
    lanes_t lanes;
    logic   has_block;
    logic   last;
  } entry_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_ROUND2,
    BK_EMIT
  } bk_state_e;

  function automatic logic [LaneW-1:0] half_swap(input logic [LaneW-1:0] d);
    half_swap = {(d[31] ? 16'hFFFF : d[15:0]), d[31:16]};
  endfunction

endpackage

// ===== src/flfbh_front.sv =====
// Front end of the four-lane block hash: lays out a full or partial block
// into four lanes and applies case folding. Depends on flfbh_pkg.
module flfbh_front (
  input  logic [63:0]                    bytes_low_i,
  input  logic [63:0]                    bytes_high_i,
  input  logic [flfbh_pkg::CountW-1:0]   valid_bytes_i,
  input  logic                           last_block_i,
  input  logic                           fold_case_i,
  output flfbh_pkg::entry_t              entry_o
);
  import flfbh_pkg::*;

  logic [BlockW-1:0] blk;
  logic [3:0]        r;
  logic [3:0]        p1;
  logic [3:0]        p2;
  logic [LaneW-1:0]  bottom;
  logic [7:0]        sbyte;
  lanes_t            part;
  lanes_t            raw;

  function automatic logic [7:0] byte_at(input logic [BlockW-1:0] b, input logic [3:0] pos);
    byte_at = b[{pos, 3'b000} +: 8];
  endfunction

  assign blk = {bytes_high_i, bytes_low_i};
  assign r   = valid_bytes_i[3:0];
  assign p1  = {r[3], 3'b000} + {1'b0, r[2], 2'b00};
  assign p2  = p1 + {2'b00, r[1], 1'b0};

  always_comb begin
    part    = '0;
    bottom  = '0;
    if (r[3]) begin
      part[0] = blk[31:0];
      part[1] = blk[63:32];
    end
    if (r[2]) begin
      part[2] = {byte_at(blk, {r[3], 3'd3}), byte_at(blk, {r[3], 3'd2}),
                 byte_at(blk, {r[3], 3'd1}), byte_at(blk, {r[3], 3'd0})};
    end
    if (r[1]) begin
      bottom = {8'h00, byte_at(blk, p1 + 4'd1), byte_at(blk, p1), 8'h00};
    end
    sbyte = byte_at(blk, p2);
    if (r[0]) begin
      bottom = bottom | {{24{sbyte[7]}}, sbyte};
    end
    part[3] = bottom;
  end

  always_comb begin
    raw = valid_bytes_i[4] ? lanes_t'(blk) : part;
    for (int k = 0; k < NumLanes; k++) begin
      entry_o.lanes[k] = fold_case_i ? (raw[k] & FoldMask) : raw[k];
    end
    entry_o.has_block = (valid_bytes_i != '0);
    entry_o.last      = last_block_i;
  end

endmodule

// ===== src/flfbh_queue.sv =====
// Short queue between the front end and the hash engine of the block hash.
// Depends on flfbh_pkg for the entry type.
module flfbh_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  flfbh_pkg::entry_t push_data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              head_valid_o,
  output flfbh_pkg::entry_t head_o
);
  import flfbh_pkg::*;

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  entry_t          mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o       = (count_q == CntW'(Depth));
  assign head_valid_o = (count_q != '0);
  assign head_o       = mem_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== src/flfbh_back.sv =====
// Hash engine of the four-lane block hash: two multiply-xor rounds per block
// on four lane multipliers, and the output register. Depends on flfbh_pkg.
module flfbh_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              head_valid_i,
  input  flfbh_pkg::entry_t head_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [31:0]       hash_value_o
);
  import flfbh_pkg::*;

  bk_state_e        state_q, state_d;
  lanes_t           lanes_q;
  lanes_t           data_q;
  logic             last_q;
  logic             out_valid_q;
  logic [LaneW-1:0] out_q;
  lanes_t           mix_data;
  lanes_t           mixed;
  logic             mix, emit, out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (head_valid_i) begin
          if (head_i.has_block) begin
            state_d = BK_ROUND2;
          end else if (head_i.last) begin
            state_d = BK_EMIT;
          end
        end
      end
      BK_ROUND2: begin
        state_d = last_q ? BK_EMIT : BK_IDLE;
      end
      BK_EMIT: begin
        if (out_free) begin
          state_d = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_comb begin
    pop_o = 1'b0;
    mix   = 1'b0;
    emit  = 1'b0;
    case (state_q)
      BK_IDLE: begin
        pop_o = head_valid_i;
        mix   = head_valid_i && head_i.has_block;
      end
      BK_ROUND2: begin
        mix = 1'b1;
      end
      BK_EMIT: begin
        emit = out_free;
      end
      default: begin
        pop_o = 1'b0;
      end
    endcase
  end

  always_comb begin
    for (int k = 0; k < NumLanes; k++) begin
      mix_data[k] = (state_q == BK_ROUND2) ? half_swap(data_q[k]) : head_i.lanes[k];
      mixed[k]    = LaneW'(lanes_q[k] * LaneMult) ^ mix_data[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      lanes_q     <= {NumLanes{LaneSeed}};
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (emit) begin
        lanes_q <= {NumLanes{LaneSeed}};
      end else if (mix) begin
        lanes_q <= mixed;
      end
      if (pop_o) begin
        last_q <= head_i.last;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      data_q <= head_i.lanes;
    end
    if (emit) begin
      out_q <= lanes_q[0] ^ lanes_q[1] ^ lanes_q[2] ^ lanes_q[3];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign hash_value_o = out_q;

`ifndef SYNTH
  a_round2_follows_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_ROUND2) |-> ($past(state_q) == BK_IDLE))
    else $error("Second round entered without a first round.");

  a_emit_reseeds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> (lanes_q == {NumLanes{LaneSeed}}))
    else $error("Lanes were not reseeded after a hash was emitted.");

  a_result_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == BK_EMIT))
    else $error("Result appeared without an emit step.");
`endif

endmodule

// ===== src/four_lane_fnv_block_hash.sv =====
// Top level of the four-lane block hash: front end, queue and hash engine.
// Depends on flfbh_pkg, flfbh_front, flfbh_queue and flfbh_back.
//
//   Channel  Direction  Handshake              Payload
//   in       input      in_valid_i/in_stall_o  bytes_low_i bytes_high_i valid_bytes_i
//                                              last_block_i fold_case_i
//   out      output     out_valid_o/out_stall_i hash_value_o
//
// A block takes two multiply rounds of the four lane multipliers in the hash engine,
// one in the idle state and one in the second-round state; an empty item is popped
// with no round, and a last item passes through the emit state to load the output register.
// Reset seeds all lanes, empties the queue and clears the output valid flag.
// The queue absorbs up to QueueDepth transactions while the engine or the output
// is stalled; in_stall_o is high only when the queue is full.
module four_lane_fnv_block_hash #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [63:0]                  bytes_low_i,
  input  logic [63:0]                  bytes_high_i,
  input  logic [flfbh_pkg::CountW-1:0] valid_bytes_i,
  input  logic                         last_block_i,
  input  logic                         fold_case_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [31:0]                  hash_value_o
);
  import flfbh_pkg::*;

  entry_t front_entry;
  entry_t head;
  logic   head_valid;
  logic   pop;

  flfbh_front u_front (
    .bytes_low_i   (bytes_low_i),
    .bytes_high_i  (bytes_high_i),
    .valid_bytes_i (valid_bytes_i),
    .last_block_i  (last_block_i),
    .fold_case_i   (fold_case_i),
    .entry_o       (front_entry)
  );

  flfbh_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (in_valid_i),
    .push_data_i  (front_entry),
    .full_o       (in_stall_o),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  flfbh_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .hash_value_o (hash_value_o)
  );

endmodule

// ===== verif/four_lane_fnv_block_hash_test.sv =====
// Self-checking testbench for four_lane_fnv_block_hash: directed and random keys
// checked against a lane-by-lane hash predictor under varied idle and stall patterns.
// Depends on flfbh_pkg and four_lane_fnv_block_hash.
`timescale 1ns / 100ps

module four_lane_fnv_block_hash_test;

  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned DrainCycles = 24;
  localparam int unsigned FullCount   = 16;

  localparam logic [31:0] FnvOffset = 32'h811c_9dc5;
  localparam logic [31:0] FnvPrime  = 32'h0100_0193;
  localparam logic [31:0] CaseMask  = 32'hDFDF_DFDF;

  logic                         clk_i;
  logic                         rst_ni = 1'b0;
  logic                         in_valid_i = 1'b0;
  logic                         in_stall_o;
  logic [63:0]                  bytes_low_i = '0;
  logic [63:0]                  bytes_high_i = '0;
  logic [flfbh_pkg::CountW-1:0] valid_bytes_i = '0;
  logic                         last_block_i = 1'b0;
  logic                         fold_case_i = 1'b0;
  logic                         out_valid_o;
  logic                         out_stall_i = 1'b0;
  logic [31:0]                  hash_value_o;

  logic [31:0]  lane_state [4] = '{FnvOffset, FnvOffset, FnvOffset, FnvOffset};
  logic [31:0]  hash_queue [$];
  int unsigned  error_count = 0;
  int unsigned  cycle_count = 0;
  int unsigned  idle_pct = 0;
  int unsigned  stall_pct = 0;

  four_lane_fnv_block_hash DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .bytes_low_i   (bytes_low_i),
    .bytes_high_i  (bytes_high_i),
    .valid_bytes_i (valid_bytes_i),
    .last_block_i  (last_block_i),
    .fold_case_i   (fold_case_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .hash_value_o  (hash_value_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("[four_lane_fnv_block_hash] ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (hash_queue.size() == 0) begin
        $display("%0t: unexpected hash transaction, expected none, actual %08h",
                 $time, hash_value_o);
        error_count++;
      end else begin
        if (hash_value_o !== hash_queue[0]) begin
          $display("%0t: hash mismatch, expected %08h, actual %08h",
                   $time, hash_queue[0], hash_value_o);
          error_count++;
        end
        void'(hash_queue.pop_front());
      end
    end
  end

  function automatic logic [63:0] random_word64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [7:0] block_byte(logic [127:0] blk, int unsigned pos);
    return blk[8 * (pos & 15) +: 8];
  endfunction

  function automatic logic [31:0] block_word(logic [127:0] blk, int unsigned pos);
    return {block_byte(blk, pos + 3), block_byte(blk, pos + 2),
            block_byte(blk, pos + 1), block_byte(blk, pos)};
  endfunction

  // Updates the lane hashes for one accepted transaction and returns the hash on the last block.
  task automatic absorb_block(input logic [63:0] lo, input logic [63:0] hi,
                              input logic [4:0] cnt, input logic last, input logic fold,
                              output logic emit, output logic [31:0] hash);
    logic [127:0] blk;
    logic [31:0]  lane_data [4];
    logic [31:0]  d;
    logic [31:0]  h;
    logic [31:0]  bottom;
    logic [7:0]   sb;
    int unsigned  n;
    int unsigned  p;
    blk = {hi, lo};
    n = (cnt > FullCount) ? FullCount : cnt;
    if (n != 0) begin
      if (n == FullCount) begin
        for (int k = 0; k < 4; k++) lane_data[k] = block_word(blk, 4 * k);
      end else begin
        p = 0;
        bottom = '0;
        for (int k = 0; k < 3; k++) lane_data[k] = '0;
        if (n[3]) begin
          lane_data[0] = block_word(blk, 0);
          lane_data[1] = block_word(blk, 4);
          p = 8;
        end
        if (n[2]) begin
          lane_data[2] = block_word(blk, p);
          p += 4;
        end
        if (n[1]) begin
          bottom = {8'h00, block_byte(blk, p + 1), block_byte(blk, p), 8'h00};
          p += 2;
        end
        if (n[0]) begin
          sb = block_byte(blk, p);
          bottom |= {{24{sb[7]}}, sb};
        end
        lane_data[3] = bottom;
      end
      for (int k = 0; k < 4; k++) begin
        d = fold ? (lane_data[k] & CaseMask) : lane_data[k];
        h = (lane_state[k] * FnvPrime) ^ d;
        d = {(d[31] ? 16'hFFFF : d[15:0]), d[31:16]};
        lane_state[k] = (h * FnvPrime) ^ d;
      end
    end
    emit = last;
    hash = lane_state[0] ^ lane_state[1] ^ lane_state[2] ^ lane_state[3];
    if (last) begin
      for (int k = 0; k < 4; k++) lane_state[k] = FnvOffset;
    end
  endtask

  task automatic send_block(input logic [63:0] lo, input logic [63:0] hi,
                            input logic [4:0] cnt, input logic last, input logic fold);
    logic        emit;
    logic [31:0] hash;
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    bytes_low_i   <= lo;
    bytes_high_i  <= hi;
    valid_bytes_i <= cnt;
    last_block_i  <= last;
    fold_case_i   <= fold;
    do @(posedge clk_i); while (in_stall_o);
    absorb_block(lo, hi, cnt, last, fold, emit, hash);
    if (emit) hash_queue.push_back(hash);
  endtask

  task automatic test_empty_and_full();
    send_block(random_word64(), random_word64(), 5'd0, 1'b1, 1'b0);
    send_block('0, '0, 5'd16, 1'b1, 1'b0);
    send_block('1, '1, 5'd16, 1'b1, 1'b1);
    send_block(random_word64(), random_word64(), 5'd16, 1'b0, 1'b0);
    send_block(random_word64(), random_word64(), 5'd0, 1'b0, 1'b1);
    send_block(random_word64(), random_word64(), 5'd16, 1'b1, 1'b1);
  endtask

  task automatic test_partial_layouts();
    logic [4:0] r;
    for (int i = 1; i < 16; i++) begin
      r = 5'(i);
      send_block(random_word64() | 64'h8080_8080_8080_8080, random_word64(), r, 1'b1, r[0]);
    end
  endtask

  task automatic test_oversized_counts();
    send_block(random_word64(), random_word64(), 5'd17, 1'b1, 1'b0);
    send_block(random_word64(), random_word64(), 5'd31, 1'b1, 1'b1);
  endtask

  task automatic test_random_keys(input int unsigned idle, input int unsigned stall,
                                  input int unsigned items);
    int unsigned sent;
    int unsigned blocks;
    logic        fold;
    logic        last;
    logic [4:0]  cnt;
    idle_pct  = idle;
    stall_pct = stall;
    sent = 0;
    while (sent < items) begin
      blocks = $urandom_range(1, 6);
      fold = 1'($urandom_range(1));
      for (int b = 1; b <= blocks; b++) begin
        last = (b == blocks);
        if ($urandom_range(9) == 0) cnt = 5'($urandom_range(31));
        else if (last) cnt = 5'($urandom_range(16));
        else cnt = 5'd16;
        if ($urandom_range(9) == 0) fold = ~fold;
        send_block(random_word64(), random_word64(), cnt, last, fold);
        if (cnt != 0 || last) sent++;
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_and_full();
    test_partial_layouts();
    test_oversized_counts();
    test_random_keys(0, 0, 225);
    test_random_keys(54, 0, 225);
    test_random_keys(0, 54, 225);
    test_random_keys(15, 15, 225);
    in_valid_i <= 1'b0;
    while (hash_queue.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("[four_lane_fnv_block_hash] OK");
    end else begin
      $display("[four_lane_fnv_block_hash] ERROR");
    end
    $finish;
  end

endmodule
